[design/ssf_pkg.sv]
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types, constants and lookup functions for the Stanley steering
// filter unit: command and status structs, angle constants, and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package ssf_pkg;

  // Angles are Q2.13 radians.
  localparam int ANGLE_PI_INT    = 25736;
  localparam int CORDIC_STEPS_DEF = 14;

  localparam logic [15:0] FILT_RESET = 16'd12868;  // pi/2
  localparam logic [15:0] GAIN_RESET = 16'd151;    // about 0.0023 in Q0.16

  // Fixed-point field widths.
  localparam int DIST_W  = 11;
  localparam int HEAD_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int STEER_W = 10;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_GAIN   = 1'b1;

  // Arctangent table index width.
  localparam int LUT_IDX_W = 5;

  // Reciprocal constants for the two constant divisions.
  // floor(2^24 / 13) and floor(2^32 / 3217); 3217 = 25736 / 8.
  localparam logic [20:0] RECIP13     = 21'd1290555;
  localparam logic [20:0] RECIP_STEER = 21'd1335084;
  localparam int          STEER_DIV   = 3217;
  localparam int          STEER_BIAS  = 1608;

  typedef struct packed {
    logic load;   // latch a new request and start the CORDIC
    logic step;   // one CORDIC micro-rotation
    logic sum;    // Stanley term and filter numerator
    logic mul1;   // reciprocal multiply for the divide by 13
    logic corr1;  // correction, saturation, filter state update
    logic mul2;   // reciprocal multiply for the steering scale
    logic corr2;  // correction, saturation, load output register
  } ssf_cmd_t;

  typedef struct packed {
    logic cordic_last;  // the current micro-rotation is the final one
  } ssf_sts_t;

  // atan(2^-i) in Q2.13, rounded to nearest.
  function automatic logic [12:0] atan_lut(input logic [LUT_IDX_W-1:0] idx);
    logic [12:0] v;
    unique case (idx)
      5'd0:    v = 13'd6434;
      5'd1:    v = 13'd3798;
      5'd2:    v = 13'd2007;
      5'd3:    v = 13'd1019;
      5'd4:    v = 13'd511;
      5'd5:    v = 13'd256;
      5'd6:    v = 13'd128;
      5'd7:    v = 13'd64;
      5'd8:    v = 13'd32;
      5'd9:    v = 13'd16;
      5'd10:   v = 13'd8;
      5'd11:   v = 13'd4;
      5'd12:   v = 13'd2;
      5'd13:   v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

[design/ssf_ctrl.sv]
// ----------------------------------------------------------------------------
// ssf_ctrl
// Sequencer for the steering filter: accepts requests, walks the datapath
// through its phases and owns the result handshake.
// ----------------------------------------------------------------------------
module ssf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              enable,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ssf_pkg::ssf_sts_t sts,
  output ssf_pkg::ssf_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CORDIC = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_MUL1   = 3'd3;
  localparam logic [2:0] S_CORR1  = 3'd4;
  localparam logic [2:0] S_MUL2   = 3'd5;
  localparam logic [2:0] S_CORR2  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The output register may be reloaded once its current result is taken.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && enable) begin
          cmd.load  = 1'b1;
          state_nxt = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cmd.step = 1'b1;
        if (sts.cordic_last) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_CORR1;
      end
      S_CORR1: begin
        cmd.corr1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_CORR2;
      end
      S_CORR2: begin
        if (out_free) begin
          cmd.corr2 = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.corr2 ? 1'b1 : (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/ssf_datapath.sv]
// ----------------------------------------------------------------------------
// ssf_datapath
// Arithmetic for the steering filter: iterative vectoring CORDIC, Stanley
// term, low-pass filter with its state, and the steering scale.
// ----------------------------------------------------------------------------
module ssf_datapath #(
  parameter int CORDIC_STEPS = ssf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssf_pkg::ssf_cmd_t                 cmd,
  output ssf_pkg::ssf_sts_t                 sts,
  input  logic [ssf_pkg::GAIN_W-1:0]        distance_gain,
  input  logic signed [ssf_pkg::DIST_W-1:0] in_distance_error,
  input  logic signed [ssf_pkg::HEAD_W-1:0] in_heading_angle,
  output logic [ssf_pkg::STEER_W-1:0]       out_steering
);

  localparam int XY_W  = 30;
  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int LIW   = ssf_pkg::LUT_IDX_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

  // CORDIC registers.
  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [15:0]     z_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [15:0]     head_r;

  // Filter and scale registers.
  logic signed [15:0] filt_r;
  logic [19:0]        mag_r;
  logic               neg_r;
  logic [16:0]        q1_r;
  logic [22:0]        a2_r;
  logic               neg2_r;
  logic [11:0]        q2_r;
  logic [9:0]         steer_r;

  // CORDIC step.
  logic signed [27:0]     y_init;
  logic signed [XY_W-1:0] xs, ys;
  logic signed [15:0]     atan_val;

  assign y_init   = $signed(in_distance_error) * $signed({1'b0, distance_gain});
  assign xs       = x_r >>> cnt_r;
  assign ys       = y_r >>> cnt_r;
  assign atan_val = $signed({3'b000, ssf_pkg::atan_lut(LIW'(cnt_r))});

  assign sts.cordic_last = (cnt_r == CNT_LAST);

  // Stanley term and filter numerator 3*s + 10*prev.
  logic signed [17:0] s_sum;
  logic signed [20:0] s21, p21, num;
  logic [20:0]        num_abs;

  assign s_sum   = 18'(head_r) + 18'(z_r) + 18'(ssf_pkg::ANGLE_PI_INT);
  assign s21     = 21'($signed(s_sum[17:1]));
  assign p21     = 21'(filt_r);
  assign num     = (s21 <<< 1) + s21 + (p21 <<< 3) + (p21 <<< 1);
  assign num_abs = num[20] ? 21'(-num) : 21'(num);

  // Divide by 13: reciprocal estimate, then at most one increment.
  logic [40:0] prod1;
  logic [19:0] rem1;
  logic [16:0] qc1;
  logic [15:0] filt_nxt;

  assign prod1 = 41'(mag_r) * 41'(ssf_pkg::RECIP13);
  assign rem1  = mag_r - 20'(q1_r) * 20'd13;
  assign qc1   = (rem1 >= 20'd13) ? q1_r + 17'd1 : q1_r;

  always_comb begin
    if (!neg_r) begin
      filt_nxt = (qc1 > 17'd32767) ? 16'h7fff : qc1[15:0];
    end else begin
      filt_nxt = (qc1 > 17'd32768) ? 16'h8000 : 16'(17'd0 - qc1);
    end
  end

  // Steering: floor((128*f + 1608) / 3217) equals the rounded f*1024/pi.
  logic [22:0] a2;
  logic [43:0] prod2;
  logic [22:0] rem2;
  logic [11:0] qc2;
  logic [9:0]  steer_nxt;

  assign a2    = 23'({filt_r[14:0], 7'b0000000}) + 23'(ssf_pkg::STEER_BIAS);
  assign prod2 = 44'(a2) * 44'(ssf_pkg::RECIP_STEER);
  assign rem2  = a2_r - 23'(q2_r) * 23'(ssf_pkg::STEER_DIV);
  assign qc2   = (rem2 >= 23'(ssf_pkg::STEER_DIV)) ? q2_r + 12'd1 : q2_r;

  always_comb begin
    if (neg2_r) begin
      steer_nxt = '0;
    end else if (qc2 > 12'd1023) begin
      steer_nxt = 10'd1023;
    end else begin
      steer_nxt = qc2[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      head_r <= in_heading_angle;
      x_r    <= XY_W'(65536);
      y_r    <= {{(XY_W-28){y_init[27]}}, y_init};
      z_r    <= '0;
      cnt_r  <= '0;
    end else if (cmd.step) begin
      if (!y_r[XY_W-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_val;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_val;
      end
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.sum) begin
      neg_r <= num[20];
      mag_r <= 20'(num_abs) + 20'd6;
    end
    if (cmd.mul1) begin
      q1_r <= prod1[40:24];
    end
    if (cmd.mul2) begin
      neg2_r <= filt_r[15];
      a2_r   <= a2;
      q2_r   <= prod2[43:32];
    end
    if (cmd.corr2) begin
      steer_r <= steer_nxt;
    end
  end

  // Filter state carries across requests and resets to pi/2.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= ssf_pkg::FILT_RESET;
    end else if (cmd.corr1) begin
      filt_r <= filt_nxt;
    end
  end

  assign out_steering = steer_r;

endmodule

[design/stanley_steering_filter_unit.sv]
// ----------------------------------------------------------------------------
// stanley_steering_filter_unit
// Stanley lateral controller with a first-order low-pass filter, producing a
// 10-bit steering command per enabled control tick.
// ----------------------------------------------------------------------------
// Once a request is accepted, the CORDIC does one micro-rotation per cycle,
// then the filter and scale arithmetic steps through the sum, divide by 13,
// filter update, steering multiply and output load. The next request is
// accepted only in idle, after the sequencer has finished the previous one.
// A result that is not taken holds the next one at its final step.
// A request while disabled is accepted and produces no result.
// Reset (synchronous, rst_n low): enable cleared, gain 151, filter state pi/2.
// ----------------------------------------------------------------------------
module stanley_steering_filter_unit #(
  parameter int CORDIC_STEPS = ssf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ssf_pkg::DIST_W-1:0] in_distance_error,
  input  logic signed [ssf_pkg::HEAD_W-1:0] in_heading_angle,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ssf_pkg::STEER_W-1:0]       out_steering,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [2:0]                        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  // Configuration registers. Register index is byte address bit 2, so the
  // enable flag sits at 0x0 and the distance gain at 0x4. Writes complete in
  // the access phase; the port never inserts wait states.
  logic                        enable_r, enable_nxt;
  logic [ssf_pkg::GAIN_W-1:0]  gain_r, gain_nxt;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    enable_nxt = enable_r;
    gain_nxt   = gain_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ssf_pkg::REG_ENABLE: enable_nxt = cfg_pwdata[0];
        ssf_pkg::REG_GAIN:   gain_nxt   = cfg_pwdata[ssf_pkg::GAIN_W-1:0];
        default:             enable_nxt = enable_r;
      endcase
    end
  end

  // Reads return the register addressed, zero-extended to the bus width.
  always_comb begin
    unique case (cfg_paddr[2])
      ssf_pkg::REG_ENABLE: cfg_prdata = {31'd0, enable_r};
      ssf_pkg::REG_GAIN:   cfg_prdata = {16'd0, gain_r};
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      gain_r   <= ssf_pkg::GAIN_RESET;
    end else begin
      enable_r <= enable_nxt;
      gain_r   <= gain_nxt;
    end
  end

  // The controller sequences one request at a time through the datapath.
  // The result sits in an output register, so a new request is accepted as
  // soon as the sequencer is back in idle, even while the previous steering
  // command is still waiting to be taken; only the final load of the output
  // register stalls until that register is free.
  ssf_pkg::ssf_cmd_t cmd;
  ssf_pkg::ssf_sts_t sts;

  ssf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (enable_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath forms atan(gain * distance) with a vectoring CORDIC, adds
  // the heading and pi and halves, filters against the stored angle as
  // (3*s + 10*prev)/13 with rounding, then scales by 1024/pi and saturates.
  ssf_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .distance_gain     (gain_r),
    .in_distance_error (in_distance_error),
    .in_heading_angle  (in_heading_angle),
    .out_steering      (out_steering)
  );

endmodule
